// ----- sv/mex_pkg.sv -----
// ============================================================================
// mex_pkg
// Shared types and constants of the modular exponentiation unit.
// ============================================================================
package mex_pkg;

    // Fixed width of the base field
    localparam int BASE_WIDTH = 63;

    // Step counter width: covers the base scan and every product scan
    localparam int CNT_W = 6;

    // Modulus after reset, before any write
    localparam logic [63:0] MODULUS_RESET = 64'd1000000000000000007;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_RED_WB,
        S_NEXT,
        S_DBL,
        S_ADD,
        S_WB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_RED,
        OP_RED_WB,
        OP_INIT_MUL,
        OP_INIT_SQR,
        OP_DBL,
        OP_ADD,
        OP_WB_MUL,
        OP_WB_SQR,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic shift_y;
    } t_ctrl;

    typedef struct packed {
        logic m_small;
        logic exp_zero;
        logic exp_lsb;
        logic ybit;
        logic out_free;
    } t_stat;

endpackage

// ----- sv/mex_addmod.sv -----
// ============================================================================
// mex_addmod
// Shared modular adder: (a + b + cin) mod m for a, b below m.
// ============================================================================
module mex_addmod #(
    parameter int MOD_WIDTH = 60
) (
    input  logic [MOD_WIDTH-1:0] i_a,
    input  logic [MOD_WIDTH-1:0] i_b,
    input  logic                 i_cin,
    input  logic [MOD_WIDTH-1:0] i_m,
    output logic [MOD_WIDTH-1:0] o_sum
);
    logic [MOD_WIDTH:0] sum;
    logic [MOD_WIDTH:0] diff;

    // Sum stays below 2m, so one conditional subtract reduces it
    assign sum  = {1'b0, i_a} + {1'b0, i_b} + {{MOD_WIDTH{1'b0}}, i_cin};
    assign diff = sum - {1'b0, i_m};
    assign o_sum = (sum >= {1'b0, i_m}) ? diff[MOD_WIDTH-1:0] : sum[MOD_WIDTH-1:0];

endmodule

// ----- sv/mex_ctrl.sv -----
// ============================================================================
// mex_ctrl
// Sequencer: base reduction, square-and-multiply scan, add-double steps.
// ============================================================================
module mex_ctrl #(
    parameter int MOD_WIDTH = 60
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mex_pkg::t_stat i_stat,
    output mex_pkg::t_ctrl o_ctrl,
    output logic          o_busy
);
    import mex_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_kind_mul, n_kind_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_kind_mul <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_kind_mul <= n_kind_mul;
        end
    end

    // Next state and step counter
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_kind_mul = r_kind_mul;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt   = CNT_W'(BASE_WIDTH - 1);
                    n_state = i_stat.m_small ? S_DONE : S_RED;
                end
            end
            S_RED: begin
                if (r_cnt == '0) begin
                    n_state = S_RED_WB;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_RED_WB: n_state = S_NEXT;
            S_NEXT: begin
                if (i_stat.exp_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_kind_mul = i_stat.exp_lsb;
                    n_cnt      = CNT_W'(MOD_WIDTH - 1);
                    n_state    = S_DBL;
                end
            end
            S_DBL: begin
                if (i_stat.ybit) begin
                    n_state = S_ADD;
                end else if (r_cnt == '0) begin
                    n_state = S_WB;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ADD: begin
                if (r_cnt == '0) begin
                    n_state = S_WB;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DBL;
                end
            end
            S_WB: n_state = S_NEXT;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctrl.op      = OP_NONE;
        o_ctrl.shift_y = 1'b0;
        o_busy         = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    o_ctrl.op = OP_START;
                end
            end
            S_RED:    o_ctrl.op = OP_RED;
            S_RED_WB: o_ctrl.op = OP_RED_WB;
            S_NEXT: begin
                if (!i_stat.exp_zero) begin
                    o_ctrl.op = i_stat.exp_lsb ? OP_INIT_MUL : OP_INIT_SQR;
                end
            end
            S_DBL: begin
                o_ctrl.op      = OP_DBL;
                o_ctrl.shift_y = !i_stat.ybit;
            end
            S_ADD: begin
                o_ctrl.op      = OP_ADD;
                o_ctrl.shift_y = 1'b1;
            end
            S_WB:   o_ctrl.op = r_kind_mul ? OP_WB_MUL : OP_WB_SQR;
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctrl.op = OP_LOAD_OUT;
                end
            end
            default: o_ctrl.op = OP_NONE;
        endcase
    end

endmodule

// ----- sv/modexp_large_modulus_add_double_unit.sv -----
// ============================================================================
// modexp_large_modulus_add_double_unit
// Modular exponentiation by square and multiply over one shared add-mod unit.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: base and
//   exponent. Output channel (o_out_valid / i_out_stall) returns power =
//   base^exponent mod modulus. The modulus register is written through
//   i_cfg_we / i_cfg_wdata; the user must write it only while the block
//   is idle, as the block itself does not enforce this.
//   Every arithmetic step goes through one modular adder, one step a cycle:
//   - base reduction: 63 Horner steps plus a writeback step,
//   - per exponent bit: one optional multiply and one square, each an init
//     step, MOD_WIDTH doubling steps, an add step per one bit of the
//     multiplier and a writeback step,
//   - the final square is skipped once no exponent bits remain.
//   A modulus below two skips the computation and loads 0 into the output
//   register as soon as that register is free.
//   o_in_stall is high from acceptance until the result moves
//   into the output register; the next item is taken while that result
//   still waits. A stalled result holds in the output register.
//   Reset (synchronous, active low) clears the sequencer and the output
//   valid and restores the modulus to 1000000000000000007.
// ============================================================================
module modexp_large_modulus_add_double_unit #(
    parameter int MOD_WIDTH = 60,
    parameter int EXP_WIDTH = 63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [MOD_WIDTH-1:0]           i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mex_pkg::BASE_WIDTH-1:0] i_base,
    input  logic [EXP_WIDTH-1:0]           i_exponent,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [MOD_WIDTH-1:0]           o_power
);
    import mex_pkg::*;

    // Control registers
    logic                  r_out_valid;
    logic [MOD_WIDTH-1:0]  r_modulus;

    // Payload registers
    logic [BASE_WIDTH-1:0] r_base;    // raw base, shifted out msb first
    logic [EXP_WIDTH-1:0]  r_exp;     // remaining exponent bits
    logic [MOD_WIDTH-1:0]  r_b;       // running base power
    logic [MOD_WIDTH-1:0]  r_result;  // running result
    logic [MOD_WIDTH-1:0]  r_acc;     // product / reduction accumulator
    logic [MOD_WIDTH-1:0]  r_x;       // multiplicand
    logic [MOD_WIDTH-1:0]  r_y;       // multiplier, shifted out msb first
    logic [MOD_WIDTH-1:0]  r_power;

    t_ctrl ctrl;
    t_stat stat;
    logic  busy;

    logic [MOD_WIDTH-1:0] add_a;
    logic [MOD_WIDTH-1:0] add_b;
    logic                 add_cin;
    logic [MOD_WIDTH-1:0] add_sum;

    // Status back to the sequencer
    always_comb begin
        stat.m_small  = ((r_modulus >> 1) == '0);
        stat.exp_zero = (r_exp == '0);
        stat.exp_lsb  = r_exp[0];
        stat.ybit     = r_y[MOD_WIDTH-1];
        stat.out_free = !r_out_valid || !i_out_stall;
    end

    mex_ctrl #(
        .MOD_WIDTH(MOD_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (stat),
        .o_ctrl    (ctrl),
        .o_busy    (busy)
    );

    // Operand select for the shared adder
    always_comb begin
        add_a   = r_acc;
        add_b   = r_acc;
        add_cin = 1'b0;
        case (ctrl.op)
            OP_RED: add_cin = r_base[BASE_WIDTH-1];  // r = 2r + next base bit
            OP_ADD: add_b   = r_x;                   // acc = acc + x
            default: begin
                add_b = r_acc;                       // doubling
            end
        endcase
    end

    mex_addmod #(
        .MOD_WIDTH(MOD_WIDTH)
    ) u_addmod (
        .i_a  (add_a),
        .i_b  (add_b),
        .i_cin(add_cin),
        .i_m  (r_modulus),
        .o_sum(add_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET[MOD_WIDTH-1:0];
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            // Raise on load, drop once the receiver takes the item
            if (ctrl.op == OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.shift_y) begin
            r_y <= r_y << 1;
        end
        case (ctrl.op)
            OP_START: begin
                r_base   <= i_base;
                r_exp    <= i_exponent;
                r_acc    <= '0;
                r_result <= stat.m_small ? '0 : {{(MOD_WIDTH-1){1'b0}}, 1'b1};
            end
            OP_RED: begin
                r_acc  <= add_sum;
                r_base <= r_base << 1;
            end
            OP_RED_WB: r_b <= r_acc;
            OP_INIT_MUL: begin
                r_acc <= '0;
                r_x   <= r_b;
                r_y   <= r_result;
            end
            OP_INIT_SQR: begin
                r_acc <= '0;
                r_x   <= r_b;
                r_y   <= r_b;
            end
            OP_DBL, OP_ADD: r_acc <= add_sum;
            OP_WB_MUL: begin
                r_result <= r_acc;
                r_exp[0] <= 1'b0;   // leave the square for this bit
            end
            OP_WB_SQR: begin
                r_b   <= r_acc;
                r_exp <= r_exp >> 1;
            end
            OP_LOAD_OUT: r_power <= r_result;
            default: begin
                r_power <= r_power;
            end
        endcase
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_power     = r_power;

endmodule

// ----- sv/mex_checker.sv -----
// ============================================================================
// mex_checker
// Port-level checks of the modular exponentiation unit, bound to the top.
// ============================================================================
module mex_checker #(
    parameter int MOD_WIDTH = 60
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [MOD_WIDTH-1:0] o_power
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_power))
        else $error("stalled result changed");

    // An accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after accepting an item");

    // Finishing an item always presents its result
    a_done_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_in_stall) |-> o_out_valid)
        else $error("block went idle without a result");

    // Reset leaves an empty, idle block
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the block");

endmodule

bind modexp_large_modulus_add_double_unit mex_checker #(
    .MOD_WIDTH(MOD_WIDTH)
) u_mex_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_power    (o_power)
);

// ----- sim/modexp_large_modulus_add_double_unit_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// modexp_large_modulus_add_double_unit_tb
// Self-checking bench for the square-and-multiply modular exponentiation unit.
// ============================================================================
// Drives base/exponent items with random gaps and holds off results at
// random. Every accepted item is run through a local exponentiation
// predictor, and each returned power is checked in order. The modulus is
// rewritten between phases while the unit is idle: reset value, both ends
// of its range, zero and one, and a sweep of random values. One phase holds
// the output off long enough that the unit backs up and stalls its input.
// ============================================================================
module modexp_large_modulus_add_double_unit_tb;

    import mex_pkg::*;

    localparam int MOD_WIDTH   = 60;
    localparam int EXP_WIDTH   = 63;
    localparam int CLK_HALF_NS = 2;
    // Give the tail one full worst-case latency of an item with a full
    // exponent to expose a stray result.
    localparam int TAIL_CYCLES = 16000;
    // Every item at its worst latency, plus all stalls, several times over.
    localparam int CYCLE_LIMIT = 20000000;

    localparam logic [BASE_WIDTH-1:0] BASE_MAX = {BASE_WIDTH{1'b1}};
    localparam logic [EXP_WIDTH-1:0]  EXP_MAX  = {EXP_WIDTH{1'b1}};
    localparam logic [MOD_WIDTH-1:0]  MOD_MAX  = {MOD_WIDTH{1'b1}};

    // ------------------------------------------------------------------------
    // Block ports, inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [MOD_WIDTH-1:0]  i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [BASE_WIDTH-1:0] i_base      = '0;
    logic [EXP_WIDTH-1:0]  i_exponent  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [MOD_WIDTH-1:0]  o_power;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [MOD_WIDTH-1:0] modulus_copy;      // local copy of the modulus register
    logic [MOD_WIDTH-1:0] power_q[$];        // powers still owed by the unit
    int                   fail_count  = 0;
    int                   cycle_count = 0;
    bit                   quiet_mode  = 1'b0; // no idling on either side
    int                   hold_req    = 0;    // long output hold-off, in cycles
    int                   hold_left   = 0;
    int                   stall_left  = 0;
    int                   run_left    = 0;

    modexp_large_modulus_add_double_unit #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_power     (o_power)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: x*y mod m through a wide product, and right-to-left
    // square and multiply on top of it.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, x} * {64'd0, y};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [MOD_WIDTH-1:0] mod_power(logic [BASE_WIDTH-1:0] base,
                                                       logic [EXP_WIDTH-1:0] exponent,
                                                       logic [MOD_WIDTH-1:0] modulus);
        logic [63:0]          m;
        logic [63:0]          sq;
        logic [63:0]          acc;
        logic [EXP_WIDTH-1:0] e;
        m = 64'(modulus);
        // Modulus zero or one leaves nothing but the zero residue.
        if (m < 64'd2) begin
            return '0;
        end
        sq  = 64'(base) % m;
        acc = 64'd1;
        e   = exponent;
        while (e != '0) begin
            if (e[0]) begin
                acc = mod_product(acc, sq, m);
            end
            sq = mod_product(sq, sq, m);
            e  = e >> 1;
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // Value of exactly nbits significant bits (top bit forced high).
    function automatic logic [63:0] rand_len(int nbits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (nbits < 64) begin
            v = v & ((64'd1 << nbits) - 64'd1);
        end
        v[nbits-1] = 1'b1;
        return v;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 3);
        end else if (r < 92) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(40, 3000);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one item, hold it until taken, record the expected power,
    // then idle for a random gap. Valid is left high when no gap follows.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [BASE_WIDTH-1:0] base, logic [EXP_WIDTH-1:0] exponent);
        int gap;
        i_in_valid <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        power_q.push_back(mod_power(base, exponent, modulus_copy));
        gap = (quiet_mode || $urandom_range(0, 99) < 45) ? 0 : pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed power has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (power_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Write the modulus register once the unit is idle.
    task automatic write_modulus(logic [MOD_WIDTH-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        modulus_copy = value;
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------
    // Reset modulus: zero exponent, zero base, extreme fields, base that
    // reduces to zero or to minus one.
    task automatic test_reset_modulus();
        logic [BASE_WIDTH-1:0] m_base;
        m_base = BASE_WIDTH'(modulus_copy);
        send_item('0, '0);
        send_item('0, 63'd5);
        send_item(BASE_MAX, '0);
        send_item(BASE_MAX, 63'd1);
        send_item(63'd1, EXP_MAX);
        send_item(BASE_MAX, EXP_MAX);
        send_item(m_base, 63'd3);
        send_item(m_base - 63'd1, 63'd2);
        send_item(m_base + 63'd2, 63'd61);
        send_item(63'd2, 63'd1 << 62);
    endtask

    // Both ends of the legal modulus range.
    task automatic test_modulus_extremes();
        write_modulus(MOD_WIDTH'(2));
        send_item(63'd7, EXP_MAX);
        send_item(63'd8, 63'd9);
        send_item(63'd6, '0);
        write_modulus(MOD_MAX);
        send_item(BASE_MAX, 63'h2ab);
        send_item(BASE_WIDTH'(MOD_MAX), 63'd1);
        send_item(BASE_WIDTH'(MOD_MAX) - 63'd1, 63'd2);
        send_item(BASE_WIDTH'(MOD_MAX) - 63'd1, EXP_MAX);
    endtask

    // Modulus zero and one give zero, also for a zero exponent.
    task automatic test_degenerate_modulus();
        write_modulus('0);
        send_item(63'd5, '0);
        send_item(BASE_MAX, EXP_MAX);
        write_modulus(MOD_WIDTH'(1));
        send_item(63'd5, '0);
        send_item(63'd5, 63'd3);
    endtask

    // Hold results off for a long stretch while items keep coming, so the
    // unit fills its output register and stalls the input.
    task automatic test_backpressure();
        int k;
        write_modulus(MOD_WIDTH'(mex_pkg::MODULUS_RESET));
        quiet_mode = 1'b1;
        hold_req   = 30000;
        for (k = 0; k < 6; k++) begin
            send_item(BASE_WIDTH'({$urandom, $urandom}),
                      EXP_WIDTH'(rand_len($urandom_range(1, 6))));
        end
        wait_idle();
        quiet_mode = 1'b0;
    endtask

    // Random items over a sweep of moduli. Most exponents are short to keep
    // the run brisk; some are full width, a few are zero.
    task automatic test_random_sweep();
        int                    k;
        int                    n;
        int                    r;
        logic [63:0]           m;
        logic [BASE_WIDTH-1:0] base;
        logic [EXP_WIDTH-1:0]  exponent;
        for (k = 0; k < 5; k++) begin
            case (k)
                0: m = rand_len(MOD_WIDTH);
                1: m = 64'($urandom_range(2, 1000));
                2: m = rand_len($urandom_range(2, MOD_WIDTH));
                3: m = rand_len($urandom_range(30, MOD_WIDTH));
                default: m = 64'(mex_pkg::MODULUS_RESET);
            endcase
            if (m[MOD_WIDTH-1:0] < 2) begin
                m = 64'd2;
            end
            write_modulus(m[MOD_WIDTH-1:0]);
            quiet_mode = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 15; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    base = BASE_WIDTH'({$urandom, $urandom});
                end else if (r < 85) begin
                    base = BASE_WIDTH'($urandom_range(0, 16));
                end else begin
                    base = BASE_WIDTH'(m * 64'($urandom_range(0, 4)));
                end
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    exponent = '0;
                end else if (r < 15) begin
                    exponent = EXP_WIDTH'(rand_len(EXP_WIDTH));
                end else begin
                    exponent = EXP_WIDTH'(rand_len($urandom_range(1, 14)));
                end
                send_item(base, exponent);
            end
            quiet_mode = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        modulus_copy = MOD_WIDTH'(mex_pkg::MODULUS_RESET);
        // Hold reset, then release it once.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_modulus();
        test_modulus_extremes();
        test_degenerate_modulus();
        test_backpressure();
        test_random_sweep();

        // Drain, then give a stray result time to show up.
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && power_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver stall: a requested long hold-off first, otherwise random
    // stretches of stall and flow.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left--;
            i_out_stall <= 1'b0;
        end else begin
            // Pick the next stretch; stay open in quiet phases.
            if (!quiet_mode && $urandom_range(0, 2) == 0) begin
                stall_left = pick_idle() - 1;
                i_out_stall <= 1'b1;
            end else begin
                run_left = $urandom_range(1, 40);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every accepted power against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [MOD_WIDTH-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (power_q.size() == 0) begin
                $error("power: unexpected result %0d", o_power);
                fail_count++;
            end else begin
                want = power_q.pop_front();
                if (o_power !== want) begin
                    $error("power: expected %0d, actual %0d", want, o_power);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ----- files.f -----
sv/mex_pkg.sv
sv/mex_addmod.sv
sv/mex_ctrl.sv
sv/modexp_large_modulus_add_double_unit.sv
sv/mex_checker.sv
sim/modexp_large_modulus_add_double_unit_tb.sv
